// ===== src/nds_pkg.sv =====
package nds_pkg;

    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int DEF_COMP_BITS   = 16;

    localparam int FIELD_BITS = 16;
    localparam int SLOT_BITS  = 10;
    localparam int COUNT_BITS = 11;
    localparam int COS_BITS   = 31;
    localparam int IDX_BITS   = 16;
    localparam int NUM_LANES  = 3;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN
    } nds_state_t;

    typedef struct packed {
        logic                valid;
        logic                first;
        logic                last;
        logic [IDX_BITS-1:0] idx;
    } nds_ctl_t;

endpackage

// ===== src/nds_cell.sv =====
module nds_cell
    import nds_pkg::*;
#(
    parameter int COMP_BITS = DEF_COMP_BITS,
    parameter int LANE      = 0,
    parameter int SUM_W     = 36
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [NUM_LANES*((COMP_BITS <= FIELD_BITS) ? COMP_BITS : FIELD_BITS)-1:0] probe_i,
    input  logic [NUM_LANES*((COMP_BITS <= FIELD_BITS) ? COMP_BITS : FIELD_BITS)-1:0] entry_i,
    input  logic signed [SUM_W-1:0]               sum_i,
    input  nds_ctl_t                              ctl_i,
    output logic [NUM_LANES*((COMP_BITS <= FIELD_BITS) ? COMP_BITS : FIELD_BITS)-1:0] entry_o,
    output logic signed [SUM_W-1:0]               sum_o,
    output nds_ctl_t                              ctl_o
);

    localparam bit EXT_SIGNED = (COMP_BITS <= FIELD_BITS);
    localparam int EXT        = EXT_SIGNED ? COMP_BITS : FIELD_BITS;
    localparam int VW         = EXT + 1;
    localparam int EW         = NUM_LANES * EXT;

    logic [EXT-1:0]          p_raw;
    logic [EXT-1:0]          e_raw;
    logic signed [VW-1:0]    p_val;
    logic signed [VW-1:0]    e_val;
    logic signed [2*VW-1:0]  prod;
    logic signed [SUM_W-1:0] sum_next;
    logic [EW-1:0]           entry_reg;
    logic signed [SUM_W-1:0] sum_reg;
    nds_ctl_t                ctl_reg;

    assign p_raw = probe_i[LANE*EXT +: EXT];
    assign e_raw = entry_i[LANE*EXT +: EXT];

    // Components wider than the field arrive zero extended, as the field carries no sign bit.
    assign p_val    = {(EXT_SIGNED ? p_raw[EXT-1] : 1'b0), p_raw};
    assign e_val    = {(EXT_SIGNED ? e_raw[EXT-1] : 1'b0), e_raw};
    assign prod     = p_val * e_val;
    assign sum_next = sum_i + SUM_W'(prod);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_i;
        sum_reg   <= sum_next;
    end

    assign entry_o = entry_reg;
    assign sum_o   = sum_reg;
    assign ctl_o   = ctl_reg;

endmodule

// ===== src/nds_best.sv =====
module nds_best
    import nds_pkg::*;
#(
    parameter int COMP_BITS = DEF_COMP_BITS,
    parameter int SUM_W     = 36
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic signed [SUM_W-1:0] sum_i,
    input  nds_ctl_t                ctl_i,
    output logic                    done_o,
    output logic signed [SUM_W-1:0] final_val_o,
    output logic [IDX_BITS-1:0]     final_idx_o
);

    localparam logic signed [SUM_W-1:0] LIMIT =
        SUM_W'((64'sd1 <<< (2 * COMP_BITS - 2)) - 64'sd1);

    logic signed [SUM_W-1:0] clamped;
    logic                    take;
    logic                    have_reg;
    logic signed [SUM_W-1:0] best_val_reg;
    logic [IDX_BITS-1:0]     best_idx_reg;

    always_comb
    begin
        clamped = sum_i;
        if (sum_i > LIMIT)
        begin
            clamped = LIMIT;
        end
        else if (sum_i < -LIMIT)
        begin
            clamped = -LIMIT;
        end
    end

    // Only a strictly larger value replaces the current best, so ties keep the lower index.
    assign take = ctl_i.valid && (ctl_i.first || !have_reg || (clamped > best_val_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else if (ctl_i.valid)
        begin
            have_reg <= !ctl_i.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_val_reg <= clamped;
            best_idx_reg <= ctl_i.idx;
        end
    end

    assign done_o      = ctl_i.valid && ctl_i.last;
    assign final_val_o = take ? clamped : best_val_reg;
    assign final_idx_o = take ? ctl_i.idx : best_idx_reg;

endmodule

// ===== src/nearest_direction_search_core.sv =====
// A load item writes one table entry in the cycle it is accepted and gives no result; busy
// stays low. A query over N = min(entry_count, MAX_ENTRIES) entries keeps busy high and shows
// its result on done: the table's single read port is walked one entry per cycle, and each
// entry then passes a registered read, three dot-product cells and the running-best compare.
// A query with N equal to zero answers in the next cycle with table_empty set. The result is
// shown for one cycle only and must be taken then.
module nearest_direction_search_core
    import nds_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int COMP_BITS   = DEF_COMP_BITS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       req_type,
    input  logic [SLOT_BITS-1:0]       entry_slot,
    input  logic signed [FIELD_BITS-1:0] comp_x,
    input  logic signed [FIELD_BITS-1:0] comp_y,
    input  logic signed [FIELD_BITS-1:0] comp_z,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [COUNT_BITS-1:0]      cfg_data,
    output logic                       done,
    output logic [SLOT_BITS-1:0]       best_slot,
    output logic signed [COS_BITS-1:0] best_cosine,
    output logic                       table_empty
);

    localparam bit EXT_SIGNED = (COMP_BITS <= FIELD_BITS);
    localparam int EXT        = EXT_SIGNED ? COMP_BITS : FIELD_BITS;
    localparam int VW         = EXT + 1;
    localparam int EW         = NUM_LANES * EXT;
    localparam int SUM_A      = 2 * VW + 2;
    localparam int SUM_B      = (SUM_A > 2 * COMP_BITS) ? SUM_A : 2 * COMP_BITS;
    localparam int SUM_W      = (SUM_B > 32) ? SUM_B : 32;
    localparam int AW         = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [EW-1:0]           dir_mem [MAX_ENTRIES];

    nds_state_t              state_reg;
    nds_state_t              state_next;
    logic [COUNT_BITS-1:0]   entry_count_reg;
    logic [AW-1:0]           rd_addr_reg;
    logic [AW-1:0]           rd_addr_next;
    logic [COUNT_BITS-1:0]   remain_reg;
    logic [COUNT_BITS-1:0]   remain_next;
    logic [EW-1:0]           probe_reg;
    logic [EW-1:0]           mem_q_reg;
    nds_ctl_t                ctl_q_reg;
    nds_ctl_t                ctl_issue;

    logic                    accept;
    logic                    load_hit;
    logic                    query_hit;
    logic                    empty_hit;
    logic [31:0]             slot_wide;
    logic [31:0]             count_wide;
    logic [31:0]             n_wide;
    logic [COUNT_BITS-1:0]   n_eff;
    logic [EW-1:0]           in_word;

    logic [EW-1:0]           chain_entry [NUM_LANES+1];
    logic signed [SUM_W-1:0] chain_sum   [NUM_LANES+1];
    nds_ctl_t                chain_ctl   [NUM_LANES+1];

    logic                    best_done;
    logic signed [SUM_W-1:0] best_val;
    logic [IDX_BITS-1:0]     best_idx;
    logic [31:0]             best_idx_wide;

    logic                    done_reg;
    logic [SLOT_BITS-1:0]    slot_reg;
    logic [COS_BITS-1:0]     cos_reg;
    logic                    empty_reg;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = !busy;
    assign accept    = start && !busy;
    assign slot_wide = 32'(entry_slot);
    assign load_hit  = accept && (req_type == REQ_LOAD) && (slot_wide < 32'(MAX_ENTRIES));
    assign query_hit = accept && (req_type == REQ_QUERY);

    assign count_wide = 32'(entry_count_reg);
    assign n_wide     = (count_wide > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : count_wide;
    assign n_eff      = n_wide[COUNT_BITS-1:0];
    assign empty_hit  = query_hit && (n_eff == '0);

    assign in_word = {comp_z[EXT-1:0], comp_y[EXT-1:0], comp_x[EXT-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            entry_count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            dir_mem[slot_wide[AW-1:0]] <= in_word;
        end
        mem_q_reg <= dir_mem[rd_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (query_hit)
        begin
            probe_reg <= in_word;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        rd_addr_next    = rd_addr_reg;
        remain_next     = remain_reg;
        ctl_issue       = '0;
        ctl_issue.idx   = IDX_BITS'(rd_addr_reg);
        ctl_issue.first = (rd_addr_reg == '0);
        ctl_issue.last  = (remain_reg == '0);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_hit && !empty_hit)
                begin
                    state_next   = ST_WALK;
                    rd_addr_next = '0;
                    remain_next  = n_eff - COUNT_BITS'(1);
                end
            end
            ST_WALK:
            begin
                ctl_issue.valid = 1'b1;
                if (remain_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    rd_addr_next = rd_addr_reg + AW'(1);
                    remain_next  = remain_reg - COUNT_BITS'(1);
                end
            end
            ST_DRAIN:
            begin
                if (best_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_addr_reg <= '0;
            remain_reg  <= '0;
            ctl_q_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_addr_reg <= rd_addr_next;
            remain_reg  <= remain_next;
            ctl_q_reg   <= ctl_issue;
        end
    end

    assign chain_entry[0] = mem_q_reg;
    assign chain_sum[0]   = '0;
    assign chain_ctl[0]   = ctl_q_reg;

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_cell
        nds_cell #(
            .COMP_BITS (COMP_BITS),
            .LANE      (g),
            .SUM_W     (SUM_W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .probe_i (probe_reg),
            .entry_i (chain_entry[g]),
            .sum_i   (chain_sum[g]),
            .ctl_i   (chain_ctl[g]),
            .entry_o (chain_entry[g+1]),
            .sum_o   (chain_sum[g+1]),
            .ctl_o   (chain_ctl[g+1])
        );
    end

    nds_best #(
        .COMP_BITS (COMP_BITS),
        .SUM_W     (SUM_W)
    ) u_best (
        .clk         (clk),
        .rst_n       (rst_n),
        .sum_i       (chain_sum[NUM_LANES]),
        .ctl_i       (chain_ctl[NUM_LANES]),
        .done_o      (best_done),
        .final_val_o (best_val),
        .final_idx_o (best_idx)
    );

    assign best_idx_wide = 32'(best_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= best_done || empty_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (empty_hit)
        begin
            slot_reg  <= '0;
            cos_reg   <= '0;
            empty_reg <= 1'b1;
        end
        else if (best_done)
        begin
            slot_reg  <= best_idx_wide[SLOT_BITS-1:0];
            cos_reg   <= best_val[COS_BITS-1:0];
            empty_reg <= 1'b0;
        end
    end

    assign done        = done_reg;
    assign best_slot   = slot_reg;
    assign best_cosine = signed'(cos_reg);
    assign table_empty = empty_reg;

endmodule

// ===== src/nds_checker.sv =====
module nds_checker
    import nds_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic                       req_type,
    input  logic                       done,
    input  logic [SLOT_BITS-1:0]       best_slot,
    input  logic signed [COS_BITS-1:0] best_cosine,
    input  logic                       table_empty
);

    // An empty table result carries a zero slot and a zero cosine.
    assert property (@(posedge clk) disable iff (!rst_n)
        done && table_empty |-> (best_slot == '0) && (best_cosine == '0))
    else $error("empty table result with nonzero payload");

    // The winning cosine is always clamped inside plus and minus one.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (best_cosine <= 31'sd1073741823) && (best_cosine >= -31'sd1073741823))
    else $error("best_cosine outside the clamp range");

    // A load item never produces a result in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req_type == REQ_LOAD) |=> !done)
    else $error("result strobe after a load item");

    // A query item either starts a walk or answers at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req_type == REQ_QUERY) |=> busy || (done && table_empty))
    else $error("query item neither started nor answered");

endmodule

bind nearest_direction_search_core nds_checker u_nds_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .done        (done),
    .best_slot   (best_slot),
    .best_cosine (best_cosine),
    .table_empty (table_empty)
);

// ===== verif/nearest_direction_search_core_tb.sv =====
module nearest_direction_search_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nds_pkg::*;

    localparam int     WATCHDOG_LIMIT = 20000;
    localparam int     PHASES         = 15;
    localparam longint COS_LIMIT      = (longint'(1) << (2 * DEF_COMP_BITS - 2)) - 1;
    localparam logic [FIELD_BITS-1:0] P_MAX = 16'h7fff;
    localparam logic [FIELD_BITS-1:0] N_MAX = 16'h8000;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_QUERY,
        ROW_COUNT
    } row_kind_t;

    typedef struct {
        logic [SLOT_BITS-1:0]       slot;
        logic signed [COS_BITS-1:0] cosine;
        logic                       no_entries;
    } nearest_t;

    typedef struct {
        row_kind_t              kind;
        logic [COUNT_BITS-1:0]  arg;
        logic [FIELD_BITS-1:0]  x;
        logic [FIELD_BITS-1:0]  y;
        logic [FIELD_BITS-1:0]  z;
        bit                     typed;
        nearest_t               want;
    } stim_row_t;

    logic                        clk        = 1'b0;
    logic                        rst_n      = 1'b0;
    logic                        start      = 1'b0;
    logic                        busy;
    logic                        req_type   = REQ_LOAD;
    logic [SLOT_BITS-1:0]        entry_slot = '0;
    logic signed [FIELD_BITS-1:0] comp_x    = '0;
    logic signed [FIELD_BITS-1:0] comp_y    = '0;
    logic signed [FIELD_BITS-1:0] comp_z    = '0;
    logic                        cfg_valid  = 1'b0;
    logic                        cfg_ready;
    logic [COUNT_BITS-1:0]       cfg_data   = '0;
    logic                        done;
    logic [SLOT_BITS-1:0]        best_slot;
    logic signed [COS_BITS-1:0]  best_cosine;
    logic                        table_empty;

    logic signed [FIELD_BITS-1:0] dir_x [DEF_MAX_ENTRIES];
    logic signed [FIELD_BITS-1:0] dir_y [DEF_MAX_ENTRIES];
    logic signed [FIELD_BITS-1:0] dir_z [DEF_MAX_ENTRIES];
    logic [COUNT_BITS-1:0]        search_count = '0;

    nearest_t  pending_nearest [$];
    stim_row_t stim_rows [$];

    int fail_count    = 0;
    int quiet_cycles  = 0;
    int loads_sent    = 0;
    int queries_sent  = 0;
    int empty_answers = 0;
    int clamp_answers = 0;
    int count_writes  = 0;

    int phase_counts [PHASES] = '{2047, 1, 0, 5, 1024, 2, 3, 40, 1023, 7, 64, 1, 16, 2047, 9};

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    nearest_direction_search_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .entry_slot  (entry_slot),
        .comp_x      (comp_x),
        .comp_y      (comp_y),
        .comp_z      (comp_z),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .done        (done),
        .best_slot   (best_slot),
        .best_cosine (best_cosine),
        .table_empty (table_empty)
    );

    function automatic nearest_t find_nearest(input logic signed [FIELD_BITS-1:0] px,
                                              input logic signed [FIELD_BITS-1:0] py,
                                              input logic signed [FIELD_BITS-1:0] pz);
        nearest_t res;
        longint   dot;
        longint   best;
        int       n;
        int       i;
        n = (search_count > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : int'(search_count);
        best = 0;
        res.slot = '0;
        res.no_entries = (n == 0);
        for (i = 0; i < n; i++)
        begin
            dot = longint'(px) * longint'(dir_x[i]) + longint'(py) * longint'(dir_y[i]) +
                  longint'(pz) * longint'(dir_z[i]);
            if (dot > COS_LIMIT)
                dot = COS_LIMIT;
            if (dot < -COS_LIMIT)
                dot = -COS_LIMIT;
            if (i == 0 || dot > best)
            begin
                best = dot;
                res.slot = i[SLOT_BITS-1:0];
            end
        end
        res.cosine = best[COS_BITS-1:0];
        return res;
    endfunction

    function automatic logic [FIELD_BITS-1:0] pick_comp();
        case ($urandom_range(0, 7))
            0: return N_MAX;
            1: return P_MAX;
            2: return '0;
            3: return ($urandom_range(0, 1) == 0) ? 16'hffff : 16'h0001;
            default: return FIELD_BITS'($urandom);
        endcase
    endfunction

    task automatic add_row(input row_kind_t kind, input logic [COUNT_BITS-1:0] arg,
                           input logic [FIELD_BITS-1:0] x, input logic [FIELD_BITS-1:0] y,
                           input logic [FIELD_BITS-1:0] z, input bit typed,
                           input int wslot, input longint wcos, input logic wempty);
        stim_row_t r;
        r.kind = kind;
        r.arg = arg;
        r.x = x;
        r.y = y;
        r.z = z;
        r.typed = typed;
        r.want.slot = wslot[SLOT_BITS-1:0];
        r.want.cosine = wcos[COS_BITS-1:0];
        r.want.no_entries = wempty;
        stim_rows.push_back(r);
    endtask

    task automatic issue(input logic rt, input logic [SLOT_BITS-1:0] slot,
                         input logic [FIELD_BITS-1:0] x, input logic [FIELD_BITS-1:0] y,
                         input logic [FIELD_BITS-1:0] z, input bit typed, input nearest_t want);
        nearest_t pred;
        @(negedge clk);
        start      <= 1'b1;
        req_type   <= rt;
        entry_slot <= slot;
        comp_x     <= x;
        comp_y     <= y;
        comp_z     <= z;
        do
            @(posedge clk);
        while (busy);
        if (rt == REQ_LOAD)
        begin
            dir_x[slot] = x;
            dir_y[slot] = y;
            dir_z[slot] = z;
            loads_sent++;
        end
        else
        begin
            pred = find_nearest(x, y, z);
            pending_nearest.push_back(typed ? want : pred);
            queries_sent++;
            if (pred.no_entries)
                empty_answers++;
            else if (longint'(pred.cosine) == COS_LIMIT || longint'(pred.cosine) == -COS_LIMIT)
                clamp_answers++;
        end
    endtask

    task automatic idle_cycle();
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic wait_drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_nearest.size() != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_count(input logic [COUNT_BITS-1:0] value);
        repeat (8) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        search_count = value;
        count_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin : result_check
        nearest_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_nearest.size() == 0)
                begin
                    $error("best_slot: unexpected result %0d with no query outstanding",
                           best_slot);
                    fail_count++;
                end
                else
                begin
                    want = pending_nearest.pop_front();
                    if (best_slot !== want.slot)
                    begin
                        $error("best_slot mismatch: expected %0d, got %0d", want.slot, best_slot);
                        fail_count++;
                    end
                    if (best_cosine !== want.cosine)
                    begin
                        $error("best_cosine mismatch: expected %0d, got %0d",
                               want.cosine, best_cosine);
                        fail_count++;
                    end
                    if (table_empty !== want.no_entries)
                    begin
                        $error("table_empty mismatch: expected %0b, got %0b",
                               want.no_entries, table_empty);
                        fail_count++;
                    end
                end
            end
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired after %0d cycles without progress.", quiet_cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        nearest_t              none;
        stim_row_t             r;
        int                    pct;
        int                    n_items;
        int                    n_live;
        int                    src;
        int                    p;
        int                    k;
        logic                  rt;
        logic [SLOT_BITS-1:0]  slot;
        logic [FIELD_BITS-1:0] x;
        logic [FIELD_BITS-1:0] y;
        logic [FIELD_BITS-1:0] z;

        none.slot = '0;
        none.cosine = '0;
        none.no_entries = 1'b0;

        // After reset the table is empty and entry_count is zero.
        add_row(ROW_QUERY, 0, P_MAX, 0, 0, 1, 0, 0, 1);
        add_row(ROW_LOAD, 0, P_MAX, P_MAX, P_MAX, 0, 0, 0, 0);
        add_row(ROW_LOAD, 1, N_MAX, N_MAX, N_MAX, 0, 0, 0, 0);
        add_row(ROW_LOAD, 2, P_MAX, P_MAX, P_MAX, 0, 0, 0, 0);
        add_row(ROW_LOAD, 3, 0, 0, P_MAX, 0, 0, 0, 0);
        add_row(ROW_LOAD, 1023, 0, N_MAX, 0, 0, 0, 0, 0);
        add_row(ROW_COUNT, 1, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_QUERY, 0, N_MAX, N_MAX, N_MAX, 1, 0, -COS_LIMIT, 0);
        add_row(ROW_QUERY, 0, P_MAX, P_MAX, P_MAX, 1, 0, COS_LIMIT, 0);
        add_row(ROW_COUNT, 2, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_QUERY, 1023, N_MAX, N_MAX, N_MAX, 1, 1, COS_LIMIT, 0);
        add_row(ROW_COUNT, 4, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_QUERY, 0, P_MAX, P_MAX, P_MAX, 1, 0, COS_LIMIT, 0);
        add_row(ROW_QUERY, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(ROW_QUERY, 0, 0, 0, N_MAX, 0, 0, 0, 0);
        add_row(ROW_QUERY, 512, 16'h0001, 16'hffff, 0, 0, 0, 0, 0);
        add_row(ROW_QUERY, 0, 0, 0, P_MAX, 0, 0, 0, 0);
        add_row(ROW_QUERY, 0, 16'h5a82, 16'ha57e, 16'h4000, 0, 0, 0, 0);
        add_row(ROW_COUNT, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(ROW_QUERY, 0, N_MAX, P_MAX, N_MAX, 1, 0, 0, 1);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i])
        begin
            r = stim_rows[i];
            if (r.kind == ROW_COUNT)
            begin
                wait_drain();
                write_count(r.arg);
            end
            else
                issue((r.kind == ROW_QUERY) ? REQ_QUERY : REQ_LOAD, r.arg[SLOT_BITS-1:0],
                      r.x, r.y, r.z, r.typed, r.want);
        end

        // Write every slot so that any entry_count reads only loaded entries.
        for (k = 0; k < DEF_MAX_ENTRIES; k++)
            issue(REQ_LOAD, k[SLOT_BITS-1:0], pick_comp(), pick_comp(), pick_comp(), 0, none);

        for (p = 0; p < PHASES; p++)
        begin
            wait_drain();
            write_count(phase_counts[p][COUNT_BITS-1:0]);
            pct = (p < 5) ? 29 : ((p < 10) ? 73 : 0);
            n_items = (phase_counts[p] > 64) ? 10 : 50;
            n_live = (phase_counts[p] > DEF_MAX_ENTRIES) ? DEF_MAX_ENTRIES : phase_counts[p];
            for (k = 0; k < n_items; k++)
            begin
                if ($urandom_range(0, 24) == 0)
                    wait_drain();
                else
                    while ($urandom_range(0, 99) < pct)
                        idle_cycle();
                rt = ($urandom_range(0, 1) == 0) ? REQ_LOAD : REQ_QUERY;
                if (rt == REQ_LOAD && n_live > 0 && $urandom_range(0, 2) != 0)
                    slot = SLOT_BITS'($urandom_range(0, n_live - 1));
                else
                    slot = SLOT_BITS'($urandom);
                if (rt == REQ_LOAD && $urandom_range(0, 5) == 0)
                begin
                    src = $urandom_range(0, DEF_MAX_ENTRIES - 1);
                    x = dir_x[src];
                    y = dir_y[src];
                    z = dir_z[src];
                end
                else
                begin
                    x = pick_comp();
                    y = pick_comp();
                    z = pick_comp();
                end
                issue(rt, slot, x, y, z, 0, none);
            end
        end

        wait_drain();
        repeat (1100) @(negedge clk);
        if (pending_nearest.size() != 0)
        begin
            $error("best_slot: %0d results never arrived", pending_nearest.size());
            fail_count++;
        end

        $display("Covered %0d loads and %0d queries over %0d entry_count writes.",
                 loads_sent, queries_sent, count_writes);
        $display("%0d queries answered on an empty table, %0d at the cosine clamp.",
                 empty_answers, clamp_answers);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/nds_pkg.sv
src/nds_cell.sv
src/nds_best.sv
src/nearest_direction_search_core.sv
src/nds_checker.sv
verif/nearest_direction_search_core_tb.sv
